FILE: src/zsbf_pkg.sv
// ============================================================================
// zsbf_pkg
// Shared types and constants of the zlib stored-block framer.
// ============================================================================
package zsbf_pkg;

    localparam int unsigned MAX_BLOCK_LEN_DEF = 65535;
    localparam int unsigned QUEUE_DEPTH       = 2;

    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;

    // One classified payload byte: everything the back end needs to emit
    // its full run of stream bytes.
    typedef struct packed {
        logic [7:0]  data;
        logic        zhdr;       // emit zlib header first
        logic        bhdr;       // emit stored-block header
        logic        final_blk;  // BFINAL bit of that block header
        logic [15:0] len;        // LEN of that block header
        logic        last;       // emit Adler-32 trailer after the byte
        logic [31:0] adler;      // Adler-32 after this byte
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: src/zsbf_front.sv
// ============================================================================
// zsbf_front
// Accepts payload bytes, tracks stream/block position and Adler-32, and
// pushes one descriptor per byte into the queue.
// ============================================================================
module zsbf_front #(
    parameter int unsigned MAX_BLOCK_LEN = zsbf_pkg::MAX_BLOCK_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic [31:0]      i_total_length,
    input  zsbf_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output zsbf_pkg::t_desc  o_desc
);

    localparam logic [15:0] BlkLen = 16'(MAX_BLOCK_LEN);

    logic [31:0] r_consumed,   n_consumed;
    logic [15:0] r_block_left, n_block_left;
    logic [15:0] r_adl_lo,     n_adl_lo;
    logic [15:0] r_adl_hi,     n_adl_hi;

    logic [31:0] w_total;
    logic [31:0] w_remaining;
    logic        w_last;
    logic        w_fits;
    logic [15:0] w_len;
    logic        w_zhdr;
    logic        w_bhdr;
    logic [16:0] w_lo_sum;
    logic [16:0] w_hi_sum;
    logic [15:0] w_lo;
    logic [15:0] w_hi;
    logic        w_accept;

    always_comb begin
        w_total     = (i_total_length == 32'd0) ? 32'd1 : i_total_length;
        w_remaining = (w_total > r_consumed) ? (w_total - r_consumed) : 32'd1;
        w_last      = ({1'b0, r_consumed} + 33'd1) >= {1'b0, w_total};
        w_fits      = w_remaining <= {16'd0, BlkLen};
        w_len       = w_fits ? w_remaining[15:0] : BlkLen;
        w_zhdr      = (r_consumed == 32'd0);
        w_bhdr      = (r_block_left == 16'd0);

        // Both sums stay below twice the modulus: one conditional subtract.
        w_lo_sum = {1'b0, r_adl_lo} + {9'd0, i_data_byte};
        w_lo     = (w_lo_sum >= {1'b0, zsbf_pkg::ADLER_MOD})
                 ? 16'(w_lo_sum - {1'b0, zsbf_pkg::ADLER_MOD}) : w_lo_sum[15:0];
        w_hi_sum = {1'b0, r_adl_hi} + {1'b0, w_lo};
        w_hi     = (w_hi_sum >= {1'b0, zsbf_pkg::ADLER_MOD})
                 ? 16'(w_hi_sum - {1'b0, zsbf_pkg::ADLER_MOD}) : w_hi_sum[15:0];
    end

    assign o_in_ready = !i_q_stat.full;
    assign w_accept   = i_in_valid && !i_q_stat.full;
    assign o_push     = w_accept;

    always_comb begin
        o_desc.data      = i_data_byte;
        o_desc.zhdr      = w_zhdr;
        o_desc.bhdr      = w_bhdr;
        o_desc.final_blk = w_fits;
        o_desc.len       = w_len;
        o_desc.last      = w_last;
        o_desc.adler     = {w_hi, w_lo};
    end

    always_comb begin
        n_consumed   = r_consumed;
        n_block_left = r_block_left;
        n_adl_lo     = r_adl_lo;
        n_adl_hi     = r_adl_hi;
        if (w_accept) begin
            if (w_last) begin
                n_consumed   = 32'd0;
                n_block_left = 16'd0;
                n_adl_lo     = 16'd1;
                n_adl_hi     = 16'd0;
            end else begin
                n_consumed   = r_consumed + 32'd1;
                n_block_left = (w_bhdr ? w_len : r_block_left) - 16'd1;
                n_adl_lo     = w_lo;
                n_adl_hi     = w_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_consumed   <= 32'd0;
            r_block_left <= 16'd0;
            r_adl_lo     <= 16'd1;
            r_adl_hi     <= 16'd0;
        end else begin
            r_consumed   <= n_consumed;
            r_block_left <= n_block_left;
            r_adl_lo     <= n_adl_lo;
            r_adl_hi     <= n_adl_hi;
        end
    end

endmodule

FILE: src/zsbf_fifo.sv
// ============================================================================
// zsbf_fifo
// Short descriptor queue between front and back end.
// ============================================================================
module zsbf_fifo #(
    parameter int unsigned DEPTH = zsbf_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  zsbf_pkg::t_desc   i_desc,
    input  logic              i_pop,
    output zsbf_pkg::t_desc   o_head,
    output zsbf_pkg::t_q_stat o_stat
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    zsbf_pkg::t_desc r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CntFull);
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

FILE: src/zsbf_back.sv
// ============================================================================
// zsbf_back
// Expands the queue head into zlib header, block header, payload and
// trailer bytes, one per cycle unless stalled, into a registered output stage.
// ============================================================================
module zsbf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zsbf_pkg::t_desc   i_head,
    input  zsbf_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_end_of_run,
    output logic              o_end_of_stream
);

    typedef enum logic [3:0] {
        POS_CMF,
        POS_FLG,
        POS_BFINAL,
        POS_LEN_LO,
        POS_LEN_HI,
        POS_NLEN_LO,
        POS_NLEN_HI,
        POS_DATA,
        POS_ADL3,
        POS_ADL2,
        POS_ADL1,
        POS_ADL0
    } t_pos;

    logic       r_busy;
    t_pos       r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_eor;
    logic       r_eos;

    t_pos       w_pos;
    t_pos       w_next;
    logic [7:0] w_byte;
    logic       w_done;
    logic       w_load;

    assign w_load = !i_q_stat.empty && (!r_out_valid || i_out_ready);

    always_comb begin
        if (r_busy) begin
            w_pos = r_pos;
        end else if (i_head.zhdr) begin
            w_pos = POS_CMF;
        end else if (i_head.bhdr) begin
            w_pos = POS_BFINAL;
        end else begin
            w_pos = POS_DATA;
        end
    end

    always_comb begin
        w_byte = i_head.data;
        w_next = POS_DATA;
        w_done = 1'b0;
        unique case (w_pos)
            POS_CMF: begin
                w_byte = zsbf_pkg::ZLIB_CMF;
                w_next = POS_FLG;
            end
            POS_FLG: begin
                w_byte = zsbf_pkg::ZLIB_FLG;
                w_next = i_head.bhdr ? POS_BFINAL : POS_DATA;
            end
            POS_BFINAL: begin
                w_byte = {7'd0, i_head.final_blk};
                w_next = POS_LEN_LO;
            end
            POS_LEN_LO: begin
                w_byte = i_head.len[7:0];
                w_next = POS_LEN_HI;
            end
            POS_LEN_HI: begin
                w_byte = i_head.len[15:8];
                w_next = POS_NLEN_LO;
            end
            POS_NLEN_LO: begin
                w_byte = ~i_head.len[7:0];
                w_next = POS_NLEN_HI;
            end
            POS_NLEN_HI: begin
                w_byte = ~i_head.len[15:8];
                w_next = POS_DATA;
            end
            POS_DATA: begin
                w_byte = i_head.data;
                w_next = POS_ADL3;
                w_done = !i_head.last;
            end
            POS_ADL3: begin
                w_byte = i_head.adler[31:24];
                w_next = POS_ADL2;
            end
            POS_ADL2: begin
                w_byte = i_head.adler[23:16];
                w_next = POS_ADL1;
            end
            POS_ADL1: begin
                w_byte = i_head.adler[15:8];
                w_next = POS_ADL0;
            end
            POS_ADL0: begin
                w_byte = i_head.adler[7:0];
                w_done = 1'b1;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    assign o_pop = w_load && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= POS_CMF;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_busy      <= !w_done;
            r_pos       <= w_next;
            r_out_valid <= 1'b1;
            r_out_byte  <= w_byte;
            r_eor       <= w_done;
            r_eos       <= (w_pos == POS_ADL0);
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_end_of_run    = r_eor;
    assign o_end_of_stream = r_eos;

endmodule

FILE: src/zlib_stored_block_framer.sv
// ============================================================================
// zlib_stored_block_framer
// Wraps a payload byte stream of programmed length as an uncompressed zlib
// stream: zlib header, stored-block headers, payload, Adler-32 trailer.
// ============================================================================
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | sink      | i_in_valid / o_in_ready | i_data_byte
//  out      | source    | o_out_valid/i_out_ready | o_out_byte, o_end_of_run,
//           |           |                         | o_end_of_stream
//  cfg      | APB slave | psel/penable/pready     | paddr, pwdata, prdata
//
//  Every input byte yields one output byte; a byte that opens a stream adds
//  two header bytes, one that opens a block adds five, the last byte adds four
//  trailer bytes (at most twelve output bytes per input byte). The output port,
//  one byte per transfer, sets the pace.
//  Payload-only bytes flow at one transfer per cycle while the output is not
//  stalled, passing through the descriptor queue and then the output register.
//  Reset (synchronous, active low) clears stream state and sets the length
//  register to one; no clearing pass.
//  An output stall holds the output register; the queue holds up to two
//  descriptors, the one being expanded included, and o_in_ready drops once
//  both are taken.
//
module zlib_stored_block_framer #(
    parameter int unsigned MAX_BLOCK_LEN = zsbf_pkg::MAX_BLOCK_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // payload input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    // stream output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_run,
    output logic        o_end_of_stream,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register index, taken from byte address bit 2.
    localparam logic REG_TOTAL_LENGTH = 1'b0;

    logic [31:0]       r_total_length;
    logic              w_cfg_wr;

    logic              w_push;
    logic              w_pop;
    zsbf_pkg::t_desc   w_desc;
    zsbf_pkg::t_desc   w_head;
    zsbf_pkg::t_q_stat w_q_stat;

    // ------------------------------------------------------------------
    // Configuration: write in the access phase, pready tied high.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL_LENGTH);
    assign prdata   = (paddr[2] == REG_TOTAL_LENGTH) ? r_total_length : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= 32'd1;
        end else if (w_cfg_wr) begin
            r_total_length <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Front end: classify each byte and update Adler-32.
    // ------------------------------------------------------------------
    zsbf_front #(
        .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_total_length (r_total_length),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_desc         (w_desc)
    );

    // ------------------------------------------------------------------
    // Descriptor queue: decouple input acceptance from output expansion.
    // ------------------------------------------------------------------
    zsbf_fifo #(
        .DEPTH (zsbf_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // ------------------------------------------------------------------
    // Back end: emit headers, payload and trailer one byte a cycle unless stalled.
    // ------------------------------------------------------------------
    zsbf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_end_of_run    (o_end_of_run),
        .o_end_of_stream (o_end_of_stream)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The trailer's last byte always closes its run.
    a_eos_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_stream) |-> o_end_of_run)
        else $error("end_of_stream without end_of_run");

    // A full queue only happens while the back end presents a byte.
    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("queue full with idle output stage");

    // Nothing leaves the block right after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

FILE: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for zlib_stored_block_framer: payload bytes go in with
// random gaps and back-pressure, and every zlib stream byte that comes out is
// checked against an in-bench framer model that tracks headers, stored-block
// headers, length changes between phases and the Adler-32 trailer.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Constants of the framing scheme
    // ------------------------------------------------------------------------
    localparam int unsigned BLOCK_LIMIT     = 65535;   // largest stored block
    localparam int unsigned ADLER_BASE      = 65521;   // Adler-32 modulus
    localparam logic [7:0]  ZLIB_CMF_BYTE   = 8'h78;
    localparam logic [7:0]  ZLIB_FLG_BYTE   = 8'h01;
    localparam logic [2:0]  REG_TOTAL_LEN   = 3'd0;    // total_length register
    localparam int unsigned IDLE_PERCENT    = 22;
    localparam int unsigned SETTLE_CYCLES   = 4;       // output register + queue
    localparam int unsigned HOLD_CYCLES     = 80;
    localparam int unsigned MAX_PRINTED     = 30;
    localparam int unsigned RUN_LIMIT_NS    = 500_000;

    // One byte of the zlib stream with its two flags
    typedef struct packed {
        logic [7:0] data;
        logic       end_of_run;
        logic       end_of_stream;
    } t_zbyte;

    // ------------------------------------------------------------------------
    // DUT signals, inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte  = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_end_of_run;
    logic        o_end_of_stream;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    zlib_stored_block_framer #(
        .MAX_BLOCK_LEN (BLOCK_LIMIT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_end_of_run    (o_end_of_run),
        .o_end_of_stream (o_end_of_stream),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Framer model state: its own copy of the length register and the stream
    // ------------------------------------------------------------------------
    logic [31:0] len_reg;
    logic [31:0] payload_taken;
    logic [15:0] block_due;
    int unsigned adler_a;
    int unsigned adler_b;

    t_zbyte      zlib_bytes_due[$];   // stream bytes still to come, oldest first

    int unsigned mismatches    = 0;
    int unsigned items_sent    = 0;
    int unsigned bytes_checked = 0;
    int unsigned streams_seen  = 0;
    bit          steady        = 1'b0;  // no random idling on either side while set
    int unsigned hold_left     = 0;     // receiver hold-off, in cycles

    // Return the model stream to its post-reset state (the register stays)
    function automatic void restart_stream();
        payload_taken = '0;
        block_due     = '0;
        adler_a       = 1;
        adler_b       = 0;
    endfunction

    // Compute every stream byte that one accepted payload byte causes and
    // queue them in order.
    function automatic void frame_payload_byte(input logic [7:0] b);
        longint unsigned total;
        longint unsigned taken;
        longint unsigned remaining;
        logic [15:0]     blk_len;
        logic [15:0]     blk_nlen;
        logic [31:0]     adler;
        bit              is_last;
        t_zbyte          run[$];

        total     = (len_reg == 0) ? 1 : longint'(len_reg);
        taken     = longint'(payload_taken);
        remaining = (total > taken) ? total - taken : 1;
        is_last   = (taken + 1 >= total);

        // A fresh stream opens with the zlib header
        if (payload_taken == 0) begin
            run.push_back('{ZLIB_CMF_BYTE, 1'b0, 1'b0});
            run.push_back('{ZLIB_FLG_BYTE, 1'b0, 1'b0});
        end

        // Open a stored block sized from what the stream still owes
        if (block_due == 0) begin
            blk_len  = (remaining > BLOCK_LIMIT) ? 16'(BLOCK_LIMIT) : 16'(remaining);
            blk_nlen = ~blk_len;
            run.push_back('{(remaining <= BLOCK_LIMIT) ? 8'd1 : 8'd0, 1'b0, 1'b0});
            run.push_back('{blk_len[7:0],   1'b0, 1'b0});
            run.push_back('{blk_len[15:8],  1'b0, 1'b0});
            run.push_back('{blk_nlen[7:0],  1'b0, 1'b0});
            run.push_back('{blk_nlen[15:8], 1'b0, 1'b0});
            block_due = blk_len;
        end

        run.push_back('{b, 1'b0, 1'b0});
        block_due     = block_due - 16'd1;
        payload_taken = payload_taken + 32'd1;
        adler_a       = (adler_a + b) % ADLER_BASE;
        adler_b       = (adler_b + adler_a) % ADLER_BASE;

        // Last byte of the stream: Adler-32 big-endian, then start over
        if (is_last) begin
            adler = {adler_b[15:0], adler_a[15:0]};
            run.push_back('{adler[31:24], 1'b0, 1'b0});
            run.push_back('{adler[23:16], 1'b0, 1'b0});
            run.push_back('{adler[15:8],  1'b0, 1'b0});
            run.push_back('{adler[7:0],   1'b0, 1'b1});
            restart_stream();
        end

        run[run.size() - 1].end_of_run = 1'b1;
        foreach (run[i]) zlib_bytes_due.push_back(run[i]);
    endfunction

    // Print one line per mismatch (up to a cap) and count every one
    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, steady stretches and counted hold-offs
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left   = hold_left - 1;
        end else if (steady) begin
            i_out_ready = 1'b1;
        end else begin
            i_out_ready = ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each output transfer with the oldest queued byte
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_zbyte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bytes_checked++;
            if (o_end_of_stream) streams_seen++;
            if (zlib_bytes_due.size() == 0) begin
                note_mismatch("unexpected output byte", o_out_byte, 0);
            end else begin
                want = zlib_bytes_due.pop_front();
                if (o_out_byte !== want.data)
                    note_mismatch("out_byte", o_out_byte, want.data);
                if (o_end_of_run !== want.end_of_run)
                    note_mismatch("end_of_run", o_end_of_run, want.end_of_run);
                if (o_end_of_stream !== want.end_of_stream)
                    note_mismatch("end_of_stream", o_end_of_stream, want.end_of_stream);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender and configuration helpers; all start and end on a falling edge
    // ------------------------------------------------------------------------

    // Offer one payload byte, hold it until the transfer, then predict
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_data_byte = b;
        do @(posedge i_clk); while (!o_in_ready);
        frame_payload_byte(b);
        items_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Payload content weighted toward the all-zero and all-one bytes
    function automatic logic [7:0] pick_byte();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Wait until every queued stream byte has arrived, then let the block settle
    task automatic wait_drained();
        while (zlib_bytes_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB read of the length register, checked against the model copy
    task automatic check_length_reg();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = REG_TOTAL_LEN;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== len_reg) note_mismatch("total_length readback", prdata, len_reg);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // APB write of the length register (block must be idle), then read back
    task automatic write_length(input logic [31:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_TOTAL_LEN;
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        len_reg = v;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_length_reg();
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // Reset value of the length is one: one byte makes a whole stream
    task automatic test_reset_length();
        check_length_reg();
        send_byte(8'hA5);
        wait_drained();
    endtask

    // One-byte streams with the extreme byte values
    task automatic test_single_byte_streams();
        write_length(32'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_drained();
    endtask

    // A short stream with alternating bit patterns and a lone top bit
    task automatic test_short_stream();
        write_length(32'd3);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h80);
        wait_drained();
    endtask

    // Zero length behaves like a length of one
    task automatic test_zero_length();
        write_length(32'd0);
        send_byte(8'h01);
        send_byte(8'hFE);
        wait_drained();
    endtask

    // Lengths at and beyond one block: non-final headers, then cut the stream
    // short with a smaller length so the trailer comes early
    task automatic test_length_extremes();
        write_length(32'hFFFF_FFFF);
        send_byte(8'h7F);
        send_byte(8'h10);
        wait_drained();
        write_length(32'd3);
        send_byte(8'h20);
        wait_drained();
        write_length(32'd65535);
        send_byte(8'hC3);
        wait_drained();
        write_length(32'd65536);
        send_byte(8'h3C);
        wait_drained();
        write_length(32'd2);
        send_byte(8'h99);
        wait_drained();
    endtask

    // Grow the length after a block header: the block runs dry before the
    // stream and a second header must follow
    task automatic test_block_refill();
        write_length(32'd2);
        send_byte(8'h11);
        wait_drained();
        write_length(32'd5);
        repeat (4) send_byte(pick_byte());
        wait_drained();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering, so the queue fills and o_in_ready drops
    task automatic test_output_holdoff();
        write_length(32'd9);
        steady = 1'b1;
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        repeat (24) send_byte(pick_byte());
        steady = 1'b0;
        wait_drained();
    endtask

    // Long stretch with no idling on either side
    task automatic test_back_to_back();
        write_length(32'd6);
        steady = 1'b1;
        repeat (30) send_byte(pick_byte());
        steady = 1'b0;
        wait_drained();
    endtask

    // A stream of high bytes long enough to wrap the Adler-32 high sum
    task automatic test_adler_wrap();
        write_length(32'd36);
        repeat (36) send_byte(8'($urandom_range(240, 255)));
        wait_drained();
    endtask

    // Random phases: drain, maybe change the length, send a burst; mid-stream
    // length changes come out of the mix on their own
    task automatic test_random_streams();
        int unsigned sent;
        int unsigned burst;
        int unsigned sel;
        logic [31:0] len_pick;
        sent = 0;
        while (sent < 45) begin
            wait_drained();
            sel = $urandom_range(99);
            if (sel < 55)      len_pick = 32'($urandom_range(1, 8));
            else if (sel < 63) len_pick = 32'd0;
            else if (sel < 70) len_pick = 32'hFFFF_FFFF;
            else if (sel < 77) len_pick = 32'($urandom_range(65534, 65537));
            else               len_pick = $urandom();
            // keep the current length now and then to continue a stream
            if (sel < 85) write_length(len_pick);
            burst = $urandom_range(1, 10);
            repeat (burst) send_byte(pick_byte());
            sent += burst;
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        len_reg = 32'd1;
        restart_stream();

        // hold reset, then release it on a falling edge
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_length();
        test_single_byte_streams();
        test_short_stream();
        test_zero_length();
        test_length_extremes();
        test_block_refill();
        test_output_holdoff();
        test_back_to_back();
        test_adler_wrap();
        test_random_streams();

        repeat (20) @(negedge i_clk);
        if (zlib_bytes_due.size() != 0)
            note_mismatch("stream bytes never produced", zlib_bytes_due.size(), 0);

        $display("covered %0d payload bytes, %0d stream bytes checked, %0d streams ended",
                 items_sent, bytes_checked, streams_seen);
        $display("lengths zero, one, block edge, all-ones and mid-stream changes; %s",
                 "Adler wrap, hold-off and steady bursts");
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #(RUN_LIMIT_NS);
        $display("run limit reached");
        $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/zsbf_pkg.sv
src/zsbf_front.sv
src/zsbf_fifo.sv
src/zsbf_back.sv
src/zlib_stored_block_framer.sv
tb/testbench.sv
